// ===== hdl/fqkr_pkg.sv =====
// Package for the task handle queue with keyed remove.
// Holds the operation and status codes, the result record and the default sizes.
// No dependencies.
`default_nettype none

package fqkr_pkg;

  localparam int unsigned DepthDef      = 16;
  localparam int unsigned HandleBitsDef = 16;

  // Fixed field widths on the stream ports.
  localparam int unsigned PortHandleW = 16;
  localparam int unsigned CountW      = 5;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [CountW-1:0]      count;
    logic                   now_empty;
    status_e                status;
    logic [PortHandleW-1:0] popped;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/fqkr_ram.sv =====
// Simple dual-port storage for the queue entries.
// One write port and one read port, read data registered; no package needed.
`default_nettype none

module fqkr_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fqkr_ctrl.sv =====
// Sequencer of the handle queue: keeps head and count of a circular buffer held in
// fqkr_ram, scans for a key and closes gaps one entry per cycle. Uses fqkr_pkg.
`default_nettype none

module fqkr_ctrl
  import fqkr_pkg::*;
#(
  parameter int unsigned DEPTH       = DepthDef,
  parameter int unsigned HANDLE_BITS = HandleBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire op_e                      in_op_i,
  input  wire logic [PortHandleW-1:0]   in_handle_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output res_t                          res_o,
  output logic                          mem_we_o,
  output logic      [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic      [HANDLE_BITS-1:0]   mem_wdata_o,
  output logic                          mem_re_o,
  output logic      [$clog2(DEPTH)-1:0] mem_raddr_o,
  input  wire logic [HANDLE_BITS-1:0]   mem_rdata_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned HB = HANDLE_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_GET   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [HB-1:0]          key_q, key_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [AW-1:0]          cur_addr_q, cur_addr_d;
  logic [AW-1:0]          prev_addr_q, prev_addr_d;
  logic [PortHandleW-1:0] popped_q, popped_d;
  status_e                status_q, status_d;

  logic [HB+PortHandleW-1:0] h_ext;
  logic [HB+PortHandleW-1:0] p_ext;
  logic [CW+CountW-1:0]      c_ext;
  logic [SW+CW-1:0]          cnt_w;
  logic [SW-1:0]             tail_sum;
  logic [AW-1:0]             tail_addr;
  logic [AW-1:0]             next_addr;
  logic [AW-1:0]             head_next;
  logic                      at_last;
  logic                      hit;

  assign h_ext = {{HB{1'b0}}, in_handle_i};
  assign p_ext = {{PortHandleW{1'b0}}, mem_rdata_i};
  assign c_ext = {{CountW{1'b0}}, cnt_q};
  assign cnt_w = {{SW{1'b0}}, cnt_q};

  // Tail position is head plus count, folded back once into the buffer.
  always_comb begin
    tail_sum = {1'b0, head_q} + cnt_w[SW-1:0];
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail_addr = tail_sum[AW-1:0];
  end

  assign next_addr = (cur_addr_q == AW'(DEPTH - 1)) ? '0 : cur_addr_q + AW'(1);
  assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign at_last   = (idx_q == cnt_q - CW'(1));
  assign hit       = (mem_rdata_i == key_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    idx_d       = idx_q;
    cur_addr_d  = cur_addr_q;
    prev_addr_d = prev_addr_q;
    popped_d    = popped_q;
    status_d    = status_q;

    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);
    mem_we_o    = 1'b0;
    mem_waddr_o = prev_addr_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = next_addr;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d      = h_ext[HB-1:0];
          popped_d   = '0;
          status_d   = ST_OK;
          idx_d      = '0;
          cur_addr_d = head_q;
          state_d    = S_DONE;
          case (in_op_i)
            OP_PUT: begin
              if (cnt_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = tail_addr;
                mem_wdata_o = h_ext[HB-1:0];
                cnt_d       = cnt_q + CW'(1);
              end
            end
            OP_GET: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                state_d     = S_GET;
              end
            end
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                status_d = ST_NOTFOUND;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                state_d     = S_SCAN;
              end
            end
            default: begin
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_GET: begin
        popped_d = p_ext[PortHandleW-1:0];
        head_d   = head_next;
        cnt_d    = cnt_q - CW'(1);
        state_d  = S_DONE;
      end
      S_SCAN: begin
        // The entry at idx_q has just come out of the memory.
        if (hit && at_last) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end else if (!hit && at_last) begin
          status_d = ST_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          idx_d       = idx_q + CW'(1);
          prev_addr_d = cur_addr_q;
          cur_addr_d  = next_addr;
          if (hit) begin
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // Move each later entry one place toward the head.
        mem_we_o = 1'b1;
        if (at_last) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          idx_d       = idx_q + CW'(1);
          prev_addr_d = cur_addr_q;
          cur_addr_d  = next_addr;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.popped    = popped_q;
    res_o.status    = status_q;
    res_o.now_empty = (cnt_q == '0);
    res_o.count     = c_ext[CountW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    idx_q       <= idx_d;
    cur_addr_q  <= cur_addr_d;
    prev_addr_q <= prev_addr_d;
    popped_q    <= popped_d;
    status_q    <= status_d;
  end

endmodule

`default_nettype wire

// ===== hdl/fifo_queue_with_keyed_remove.sv =====
// Task handle queue with put, get and remove by key; result per request.
// A put, a refused put, a get or remove on an empty queue and the unused code go from idle
// straight to the done state; a get first reads the head, and a remove on a filled queue scans
// its entries and on a hit shifts later ones toward the head. One request is in work at a time.
// Results are registered at the output; a full, unread output register stalls the next request.
// Reset empties the queue at once; entry storage is not cleared.
`default_nettype none

module fifo_queue_with_keyed_remove
  import fqkr_pkg::*;
#(
  parameter int unsigned DEPTH       = DepthDef,
  parameter int unsigned HANDLE_BITS = HandleBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // op[1:0], handle[17:2], zero[23:18]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata   // popped[15:0], status[17:16], now_empty[18],
                                          // count[23:19]
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [HANDLE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [HANDLE_BITS-1:0] mem_rdata;
  logic                   out_valid_q;
  res_t                   out_q;

  fqkr_ctrl #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tdata[1:0])),
    .in_handle_i (s_axis_tdata[17:2]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fqkr_ram #(
    .DEPTH (DEPTH),
    .WIDTH (HANDLE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ===== bench/tb_fifo_queue_with_keyed_remove.sv =====
// Self-checking bench for the task handle queue with put, get and remove by key.
// A queue model of its own predicts each result; random bursts and receiver stalls.
// Depends on fqkr_pkg and fifo_queue_with_keyed_remove.
`timescale 1ns / 100ps

module tb_fifo_queue_with_keyed_remove
  import fqkr_pkg::*;
();

  localparam int unsigned RandomItems = 1550;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned TimeoutNs   = 5_000_000;

  typedef struct packed {
    logic [PortHandleW-1:0] handle;
    op_e                    op;
  } request_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // op[1:0], handle[17:2], zero[23:18]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // popped[15:0], status[17:16], now_empty[18], count[23:19]

  fifo_queue_with_keyed_remove dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  request_t               pending_reqs[$];
  res_t                   expected_results[$];
  logic [PortHandleW-1:0] held_handles[$];

  int unsigned errors        = 0;
  int unsigned n_accepted    = 0;
  int unsigned n_checked     = 0;
  int unsigned n_put_full    = 0;
  int unsigned n_get_empty   = 0;
  int unsigned n_remove_hit  = 0;
  int unsigned n_remove_miss = 0;
  int unsigned n_nop         = 0;
  int unsigned max_held      = 0;

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Applies one request to the local copy of the queue and returns its result.
  function automatic res_t apply_request(request_t req);
    res_t res;
    bit   found;
    res        = '0;
    res.status = ST_OK;
    found      = 1'b0;
    case (req.op)
      OP_PUT: begin
        if (held_handles.size() >= DepthDef) begin
          res.status = ST_FULL;
          n_put_full++;
        end else begin
          held_handles.push_back(req.handle);
        end
      end
      OP_GET: begin
        if (held_handles.size() == 0) begin
          res.status = ST_EMPTY;
          n_get_empty++;
        end else begin
          res.popped = held_handles.pop_front();
        end
      end
      OP_REMOVE: begin
        // Only the match nearest the head goes; the rest keep their order.
        for (int i = 0; i < held_handles.size(); i++) begin
          if (!found && held_handles[i] == req.handle) begin
            held_handles.delete(i);
            found = 1'b1;
          end
        end
        res.status = found ? ST_OK : ST_NOTFOUND;
        if (found) n_remove_hit++;
        else n_remove_miss++;
      end
      default: n_nop++;
    endcase
    res.count     = CountW'(held_handles.size());
    res.now_empty = (held_handles.size() == 0);
    if (held_handles.size() > max_held) max_held = held_handles.size();
    return res;
  endfunction

  task automatic add_request(op_e op, logic [PortHandleW-1:0] handle);
    request_t req;
    req.op     = op;
    req.handle = handle;
    pending_reqs.push_back(req);
  endtask

  // Episode kinds bias the mix: filling, draining, mixed traffic and remove churn.
  function automatic op_e pick_op(int kind);
    int roll;
    int put_pct;
    int get_pct;
    int rem_pct;
    roll = $urandom_range(99);
    case (kind)
      0:       begin put_pct = 85; get_pct = 5;  rem_pct = 8;  end
      1:       begin put_pct = 10; get_pct = 70; rem_pct = 17; end
      2:       begin put_pct = 35; get_pct = 25; rem_pct = 30; end
      default: begin put_pct = 45; get_pct = 5;  rem_pct = 48; end
    endcase
    if (roll < put_pct) return OP_PUT;
    if (roll < put_pct + get_pct) return OP_GET;
    if (roll < put_pct + get_pct + rem_pct) return OP_REMOVE;
    return OP_NOP;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  request_t    next_req;
  int unsigned burst_left = 1;
  int unsigned idle_left  = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_request(next_req));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (idle_left != 0 || pending_reqs.size() == 0) begin
          if (idle_left != 0) idle_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          next_req = pending_reqs.pop_front();
          s_axis_tdata  <= {6'b0, next_req};
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            idle_left  = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver: stall behavior switches between randomly chosen modes, each held for a random span.
  int unsigned ready_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_cnt  = 0;
  logic        next_ready;
  res_t        got;
  res_t        want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report($sformatf("result 0x%06h arrived with no request outstanding", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (got.popped != want.popped)
            report($sformatf("result %0d popped 0x%04h, want 0x%04h",
                             n_checked, got.popped, want.popped));
          if (got.status != want.status)
            report($sformatf("result %0d status %0d, want %0d",
                             n_checked, got.status, want.status));
          if (got.now_empty != want.now_empty)
            report($sformatf("result %0d now_empty %0d, want %0d",
                             n_checked, got.now_empty, want.now_empty));
          if (got.count != want.count)
            report($sformatf("result %0d count %0d, want %0d",
                             n_checked, got.count, want.count));
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(3);
        mode_left  = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: next_ready = 1'b1;
        1: next_ready = 1'($urandom_range(1));
        2: next_ready = ($urandom_range(3) == 0);
        default: begin
          // Long stalls broken by a short window in which ready is high.
          if (stall_cnt == 0) stall_cnt = $urandom_range(4, 30);
          stall_cnt--;
          next_ready = (stall_cnt < 2);
        end
      endcase
      m_axis_tready <= next_ready;
    end
  end

  initial begin
    logic [PortHandleW-1:0] pool[4];
    int unsigned            n_random;
    int                     kind;
    int                     len;
    logic [PortHandleW-1:0] handle;

    // Directed opening: failures on an empty queue, the unused code, removing the
    // only entry, handle extremes and duplicates.
    add_request(OP_GET, 16'h0000);
    add_request(OP_REMOVE, 16'h0005);
    add_request(OP_NOP, 16'hFFFF);
    add_request(OP_PUT, 16'h1234);
    add_request(OP_REMOVE, 16'h1234);
    add_request(OP_PUT, 16'h0000);
    add_request(OP_PUT, 16'hFFFF);
    add_request(OP_PUT, 16'h0000);
    add_request(OP_REMOVE, 16'h0000);
    add_request(OP_REMOVE, 16'h0007);
    add_request(OP_NOP, 16'h0000);
    add_request(OP_GET, 16'hFFFF);
    add_request(OP_GET, 16'h0000);
    add_request(OP_GET, 16'h0000);

    // Fill past capacity so puts against a full queue are seen early.
    for (int i = 0; i < DepthDef + 2; i++) add_request(OP_PUT, 16'($urandom));

    n_random = 0;
    while (n_random < RandomItems) begin
      kind = $urandom_range(3);
      len  = $urandom_range(8, 40);
      // A small handle pool makes removes hit and duplicates common.
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(7) == 0) pool[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else pool[k] = 16'($urandom);
      end
      for (int j = 0; j < len; j++) begin
        handle = ($urandom_range(3) == 0) ? 16'($urandom) : pool[$urandom_range(3)];
        add_request(pick_op(kind), handle);
        n_random++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d requests, checked %0d results, peak occupancy %0d.",
             n_accepted, n_checked, max_held);
    $display("Refused puts %0d, empty gets %0d, removes hit %0d / missed %0d, no-ops %0d.",
             n_put_full, n_get_empty, n_remove_hit, n_remove_miss, n_nop);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fqkr_pkg.sv
hdl/fqkr_ram.sv
hdl/fqkr_ctrl.sv
hdl/fifo_queue_with_keyed_remove.sv
bench/tb_fifo_queue_with_keyed_remove.sv
